// File: design/jrs_pkg.sv
// ----------------------------------------------------------------------------
// jrs_pkg
// Shared constants, controller states and the command and status words that
// pass between the Josephus ring controller and its datapath.
// ----------------------------------------------------------------------------
package jrs_pkg;

  localparam int MAX_RING_DEF = 1024;
  localparam int SIZE_W       = 11;
  localparam int STEP_W       = 11;
  localparam int SURV_W       = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINK,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } jrs_state_t;

  typedef struct packed {
    logic load;
    logic link;
    logic read;
    logic eval;
    logic finish;
  } jrs_cmd_t;

  typedef struct packed {
    logic link_last;
    logic rem_one;
    logic out_free;
  } jrs_status_t;

endpackage

// File: design/jrs_ctrl.sv
// ----------------------------------------------------------------------------
// jrs_ctrl
// Sequencer for one request: load, build the ring, then alternate link reads
// and count/unlink steps until one entry remains, then hand off the result.
// ----------------------------------------------------------------------------
module jrs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  jrs_pkg::jrs_status_t status,
  output jrs_pkg::jrs_cmd_t    cmd
);

  jrs_pkg::jrs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jrs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      jrs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = jrs_pkg::ST_LINK;
        end
      end
      jrs_pkg::ST_LINK: begin
        cmd.link = 1'b1;
        if (status.link_last) begin
          state_next = jrs_pkg::ST_READ;
        end
      end
      jrs_pkg::ST_READ: begin
        if (status.rem_one) begin
          state_next = jrs_pkg::ST_DONE;
        end else begin
          cmd.read   = 1'b1;
          state_next = jrs_pkg::ST_EVAL;
        end
      end
      jrs_pkg::ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = jrs_pkg::ST_READ;
      end
      jrs_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = jrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = jrs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/jrs_datapath.sv
// ----------------------------------------------------------------------------
// jrs_datapath
// Link stores, ring registers and the output register. Each store has one
// write port and one registered read port addressed by the current entry.
// ----------------------------------------------------------------------------
module jrs_datapath #(
  parameter int MAX_RING = jrs_pkg::MAX_RING_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  jrs_pkg::jrs_cmd_t             cmd,
  output jrs_pkg::jrs_status_t          status,
  input  logic [jrs_pkg::SIZE_W-1:0]    circle_size,
  input  logic [jrs_pkg::STEP_W-1:0]    step_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [jrs_pkg::SURV_W-1:0]    survivor
);

  localparam int AW    = $clog2(MAX_RING);
  localparam int CLG_N = $clog2(MAX_RING + 1);
  localparam int NW    = (CLG_N > jrs_pkg::SIZE_W) ? CLG_N : jrs_pkg::SIZE_W;

  logic [AW-1:0] right_mem [MAX_RING];
  logic [AW-1:0] left_mem  [MAX_RING];

  logic [NW-1:0]             ring_n;
  logic [NW-1:0]             remaining;
  logic [jrs_pkg::STEP_W-1:0] step_k;
  logic [jrs_pkg::STEP_W-1:0] counter;
  logic [AW-1:0]             position;
  logic [AW-1:0]             idx;
  logic [AW-1:0]             right_q;
  logic [AW-1:0]             left_q;

  logic [NW-1:0]  size_ext;
  logic [NW-1:0]  size_clamp;
  logic [AW-1:0]  last_idx;
  logic           hit;
  logic           right_we;
  logic [AW-1:0]  right_wa;
  logic [AW-1:0]  right_wd;
  logic           left_we;
  logic [AW-1:0]  left_wa;
  logic [AW-1:0]  left_wd;

  always_comb begin
    size_ext = NW'(circle_size);
    if (size_ext == '0) begin
      size_clamp = NW'(1);
    end else if (size_ext > NW'(MAX_RING)) begin
      size_clamp = NW'(MAX_RING);
    end else begin
      size_clamp = size_ext;
    end
  end

  assign last_idx = AW'(ring_n - NW'(1));
  assign hit      = (counter == step_k);

  always_comb begin
    right_we = 1'b0;
    right_wa = idx;
    right_wd = (idx == last_idx) ? '0 : idx + AW'(1);
    left_we  = 1'b0;
    left_wa  = idx;
    left_wd  = (idx == '0) ? last_idx : idx - AW'(1);
    if (cmd.link) begin
      right_we = 1'b1;
      left_we  = 1'b1;
    end else if (cmd.eval && hit) begin
      // unlink: right[l] = r, left[r] = l
      right_we = 1'b1;
      right_wa = left_q;
      right_wd = right_q;
      left_we  = 1'b1;
      left_wa  = right_q;
      left_wd  = left_q;
    end
  end

  always_ff @(posedge clk) begin
    if (right_we) begin
      right_mem[right_wa] <= right_wd;
    end
    if (cmd.read) begin
      right_q <= right_mem[position];
    end
  end

  always_ff @(posedge clk) begin
    if (left_we) begin
      left_mem[left_wa] <= left_wd;
    end
    if (cmd.read) begin
      left_q <= left_mem[position];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ring_n    <= size_clamp;
      remaining <= size_clamp;
      step_k    <= (step_count == '0) ? jrs_pkg::STEP_W'(1) : step_count;
      counter   <= jrs_pkg::STEP_W'(1);
      position  <= '0;
      idx       <= '0;
    end else if (cmd.link) begin
      idx <= idx + AW'(1);
    end else if (cmd.eval) begin
      position <= right_q;
      if (hit) begin
        remaining <= remaining - NW'(1);
        counter   <= jrs_pkg::STEP_W'(1);
      end else begin
        counter <= counter + jrs_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      survivor <= jrs_pkg::SURV_W'(position);
    end
  end

  assign status.link_last = (idx == last_idx);
  assign status.rem_one   = (remaining == NW'(1));
  assign status.out_free  = !out_valid || out_ready;

endmodule

// File: design/josephus_ring_survivor.sv
// ----------------------------------------------------------------------------
// josephus_ring_survivor
// Steps: a load, one link write per ring entry, a link read and an evaluate per
//   walk step, and a finish once the output is free; the walk takes about N*K steps.
// Throughput: one request in flight; the next word is accepted the cycle after
//   the result is handed to the output register.
// Reset clears the controller and output valid; link stores are not cleared.
// ----------------------------------------------------------------------------
module josephus_ring_survivor #(
  parameter int MAX_RING = jrs_pkg::MAX_RING_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [jrs_pkg::SIZE_W-1:0]    circle_size,
  input  logic [jrs_pkg::STEP_W-1:0]    step_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [jrs_pkg::SURV_W-1:0]    survivor
);

  jrs_pkg::jrs_cmd_t    cmd;
  jrs_pkg::jrs_status_t status;

  jrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  jrs_datapath #(
    .MAX_RING (MAX_RING)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .circle_size (circle_size),
    .step_count  (step_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .survivor    (survivor)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.link, cmd.read, cmd.eval, cmd.finish}))
    else $error("more than one datapath command");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready after accepting a word");

  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.eval |-> $past(cmd.read))
    else $error("step evaluated without link read");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("result not presented after finish");

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for josephus_ring_survivor. A queue-fed driver offers
// ring requests (size, step) on the input channel and a monitor checks every
// survivor word against an in-bench ring walk. The run covers directed corner
// cases and random requests under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;

  localparam int RING_MAX      = jrs_pkg::MAX_RING_DEF;
  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 6;
  localparam int CYCLE_LIMIT   = 8_000_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    logic [jrs_pkg::SIZE_W-1:0] size;
    logic [jrs_pkg::STEP_W-1:0] step;
  } ring_req_t;

  typedef struct {
    logic [jrs_pkg::SIZE_W-1:0] size;
    logic [jrs_pkg::STEP_W-1:0] step;
    logic [jrs_pkg::SURV_W-1:0] survivor;
  } survivor_exp_t;

  logic                       clk         = 1'b0;
  logic                       rst         = 1'b1;
  logic                       in_valid    = 1'b0;
  logic                       in_ready;
  logic [jrs_pkg::SIZE_W-1:0] circle_size = '0;
  logic [jrs_pkg::STEP_W-1:0] step_count  = '0;
  logic                       out_valid;
  logic                       out_ready   = 1'b0;
  logic [jrs_pkg::SURV_W-1:0] survivor;

  ring_req_t     req_queue[$];
  survivor_exp_t survivor_queue[$];
  logic [jrs_pkg::SURV_W-1:0] ring_next [RING_MAX];
  logic [jrs_pkg::SURV_W-1:0] ring_prev [RING_MAX];

  int unsigned tx_idle_pct   = 29;
  int unsigned rx_idle_pct   = 46;
  logic        hold_arm      = 1'b0;
  logic        hold_done     = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches    = 0;

  josephus_ring_survivor dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .circle_size (circle_size),
    .step_count  (step_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .survivor    (survivor)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [jrs_pkg::SURV_W-1:0] josephus_survivor(
      input logic [jrs_pkg::SIZE_W-1:0] size_in,
      input logic [jrs_pkg::STEP_W-1:0] step_in);
    int unsigned ring_n;
    int unsigned step_k;
    int unsigned alive;
    int unsigned pos;
    int unsigned count;
    int unsigned idx;
    logic [jrs_pkg::SURV_W-1:0] cur;
    logic [jrs_pkg::SURV_W-1:0] lft;
    logic [jrs_pkg::SURV_W-1:0] rgt;
    ring_n = (size_in == '0) ? 32'd1 : 32'(size_in);
    if (ring_n > RING_MAX) ring_n = RING_MAX;
    step_k = (step_in == '0) ? 32'd1 : 32'(step_in);
    alive = ring_n;
    pos = 0;
    count = 1;
    if (ring_n > 1) begin
      for (idx = 0; idx < ring_n; idx++) begin
        ring_next[idx[jrs_pkg::SURV_W-1:0]] =
          jrs_pkg::SURV_W'((idx + 1 == ring_n) ? 32'd0 : idx + 1);
        ring_prev[idx[jrs_pkg::SURV_W-1:0]] =
          jrs_pkg::SURV_W'((idx == 0) ? ring_n - 1 : idx - 1);
      end
      while (alive > 1) begin
        cur = pos[jrs_pkg::SURV_W-1:0];
        if (count == step_k) begin
          // drop the current entry, restart the count at its right neighbor
          lft = ring_prev[cur];
          rgt = ring_next[cur];
          alive--;
          ring_next[lft] = rgt;
          ring_prev[rgt] = lft;
          pos = 32'(rgt);
          count = 1;
        end else begin
          count = (count + 1) & 32'h7FF;
          pos = 32'(ring_next[cur]);
        end
      end
    end
    return pos[jrs_pkg::SURV_W-1:0];
  endfunction

  task automatic add_request(input int unsigned size_val, input int unsigned step_val);
    ring_req_t req;
    req.size = size_val[jrs_pkg::SIZE_W-1:0];
    req.step = step_val[jrs_pkg::STEP_W-1:0];
    req_queue.push_back(req);
  endtask

  task automatic wait_for_drain();
    do @(negedge clk);
    while (req_queue.size() != 0 || in_valid || survivor_queue.size() != 0);
  endtask

  task automatic run_random_phase(input int unsigned count, input int unsigned tx_pct,
                                  input int unsigned rx_pct);
    int unsigned pick;
    @(negedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 80) add_request($urandom_range(40, 1), $urandom_range(40, 1));
      else if (pick < 90) add_request($urandom_range(2047, 0), $urandom_range(4, 0));
      else add_request($urandom_range(4, 0), $urandom_range(2047, 0));
    end
    wait_for_drain();
  endtask

  // driver: offer the next pending word, hold it until accepted
  always @(posedge clk) begin : drive
    ring_req_t     req;
    survivor_exp_t exp_word;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        exp_word.size     = circle_size;
        exp_word.step     = step_count;
        exp_word.survivor = josephus_survivor(circle_size, step_count);
        survivor_queue.push_back(exp_word);
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (req_queue.size() == 0 || $urandom_range(99) < tx_idle_pct) begin
          in_valid <= 1'b0;
        end else begin
          req = req_queue.pop_front();
          in_valid    <= 1'b1;
          circle_size <= req.size;
          step_count  <= req.step;
        end
      end
    end
  end

  // long output stall: hold off the receiver once
  always @(posedge clk) begin : hold
    if (rst) begin
      hold_left <= 0;
    end else if (hold_arm && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: check each survivor word, stall the output at random
  always @(posedge clk) begin : observe
    survivor_exp_t exp_word;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (survivor_queue.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("unexpected survivor word %0d at cycle %0d", survivor, cycle_count);
          mismatches++;
        end else begin
          exp_word = survivor_queue.pop_front();
          words_checked++;
          if (survivor !== exp_word.survivor) begin
            if (mismatches < REPORT_MAX)
              $display("survivor mismatch N=%0d K=%0d: expected %0d, got %0d",
                       exp_word.size, exp_word.step, exp_word.survivor, survivor);
            mismatches++;
          end
        end
      end
      out_ready <= (hold_left == 0) && !(hold_arm && !hold_done) &&
                   ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d with %0d survivor words outstanding",
               cycle_count, survivor_queue.size());
      $display("josephus_ring_survivor verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // ring of one first, so the long output stall backs up the input
    add_request(1, 1);
    add_request(1, 2047);
    add_request(0, 0);
    add_request(0, 5);
    add_request(2, 0);
    add_request(2, 1);
    add_request(2, 2);
    add_request(2, 2047);
    add_request(3, 1024);
    add_request(5, 3);
    add_request(7, 3);
    add_request(41, 3);
    add_request(10, 10);
    add_request(13, 1);
    add_request(6, 1023);
    add_request(16, 17);
    add_request(1024, 1);
    add_request(1024, 2);
    add_request(1025, 3);
    add_request(2047, 1);
    add_request(1500, 2);
    add_request(64, 64);
    add_request(4, 2046);
    hold_arm = 1'b1;
    wait_for_drain();
    run_random_phase(26, 29, 46);
    run_random_phase(26, 46, 29);
    run_random_phase(25, 0, 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("ran %0d ring requests (sizes and steps 0..2047, rings of one, saturated rings)",
             words_sent);
    $display("checked %0d survivor words in %0d cycles, %0d mismatches",
             words_checked, cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("josephus_ring_survivor verification clean");
    end else begin
      $display("josephus_ring_survivor verification failed");
    end
    $finish;
  end

endmodule

// File: josephus_ring_survivor.f
design/jrs_pkg.sv
design/jrs_ctrl.sv
design/jrs_datapath.sv
design/josephus_ring_survivor.sv
bench/tb.sv
